FILE: sv/multifactor_job_priority_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multifactor job priority scorer.
// Checks are sampled on clk_i and suspended during reset.
// ---------------------------------------------------------------------------
`ifndef MULTIFACTOR_JOB_PRIORITY_ASSERT_SVH
`define MULTIFACTOR_JOB_PRIORITY_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define MJP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property that only applies while an output item is valid.
`define MJP_ASSERT_OUT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    m_axis_tvalid |-> (prop)) else $error(msg);

`endif

FILE: sv/mjp_pkg.sv
// ---------------------------------------------------------------------------
// mjp_pkg
// Shared types and constants of the multifactor job priority scorer.
// ---------------------------------------------------------------------------
package mjp_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned FACTOR_W  = FRAC_BITS + 1;
  localparam int unsigned WEIGHT_W  = 24;
  localparam int unsigned PROD_W    = FACTOR_W + WEIGHT_W;
  localparam int unsigned SUM_W     = PROD_W + 3;
  localparam int unsigned NICE_BIAS = 10000;

  localparam logic [FACTOR_W-1:0] FX_ONE = FACTOR_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    KIND_COMPUTED = 2'd0,
    KIND_DIRECT   = 2'd1,
    KIND_NOT_ELIG = 2'd2,
    KIND_NO_DET   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_MAX_AGE   = 3'd0,
    REG_AGE_W     = 3'd1,
    REG_FS_W      = 3'd2,
    REG_SIZE_W    = 3'd3,
    REG_PART_W    = 3'd4,
    REG_QOS_W     = 3'd5,
    REG_FAVOR     = 3'd6,
    REG_NODE_CNT  = 3'd7
  } reg_e;

  // Per-item data carried alongside the dividers.
  typedef struct packed {
    kind_e               kind;
    logic [31:0]         direct_priority;
    logic [FACTOR_W-1:0] fs;
    logic [FACTOR_W-1:0] part;
    logic [FACTOR_W-1:0] qos;
    logic [15:0]         nice;
    logic                age_sat;
    logic                size_sat;
    logic                size_one;
  } side_t;

endpackage

FILE: sv/mjp_front.sv
// ---------------------------------------------------------------------------
// mjp_front
// Decode one job, form the simple factors and the divider operands.
// ---------------------------------------------------------------------------
module mjp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [31:0]           now_time_i,
  input  logic [31:0]           eligible_time_i,
  input  logic                  has_details_i,
  input  logic                  direct_set_i,
  input  logic [31:0]           direct_priority_i,
  input  logic [15:0]           requested_nodes_i,
  input  logic                  has_account_i,
  input  logic [16:0]           normalized_shares_i,
  input  logic [16:0]           effective_usage_i,
  input  logic [16:0]           partition_norm_priority_i,
  input  logic [16:0]           qos_norm_priority_i,
  input  logic [15:0]           nice_value_i,
  input  logic [31:0]           max_age_i,
  input  logic                  fs_enable_i,
  input  logic                  small_first_i,
  input  logic [15:0]           node_count_i,
  output logic                  valid_o,
  output mjp_pkg::side_t        side_o,
  output logic [31:0]           age_num_o,
  output logic [15:0]           size_num_o
);
  import mjp_pkg::*;

  logic                valid_q;
  side_t               side_d, side_q;
  logic [31:0]         diff;
  logic [31:0]         age_num_d, age_num_q;
  logic [15:0]         size_num_d, size_num_q;
  logic [FACTOR_W:0]   fs_top, fs_diff;
  logic [FACTOR_W-1:0] fs_half;

  assign diff    = now_time_i - eligible_time_i;
  assign fs_top  = {1'b0, normalized_shares_i} + {1'b0, FX_ONE};
  assign fs_diff = fs_top - {1'b0, effective_usage_i};
  assign fs_half = fs_diff[FACTOR_W:1];

  always_comb begin
    side_d.direct_priority = direct_priority_i;
    side_d.nice            = nice_value_i;
    side_d.part = (partition_norm_priority_i > FX_ONE) ? FX_ONE : partition_norm_priority_i;
    side_d.qos  = (qos_norm_priority_i > FX_ONE) ? FX_ONE : qos_norm_priority_i;
    side_d.age_sat  = (diff >= max_age_i);
    side_d.size_sat = (requested_nodes_i >= node_count_i);
    side_d.size_one = small_first_i && (requested_nodes_i == 16'd0);
    if (direct_set_i) begin
      side_d.kind = KIND_DIRECT;
    end else if (!has_details_i) begin
      side_d.kind = KIND_NO_DET;
    end else if (eligible_time_i == 32'd0 || eligible_time_i > now_time_i) begin
      side_d.kind = KIND_NOT_ELIG;
    end else begin
      side_d.kind = KIND_COMPUTED;
    end
    if (!has_account_i || !fs_enable_i || effective_usage_i >= fs_top[FACTOR_W-1:0]
        && !fs_top[FACTOR_W]) begin
      side_d.fs = '0;
    end else if (fs_half > FX_ONE) begin
      side_d.fs = FX_ONE;
    end else begin
      side_d.fs = fs_half;
    end
    age_num_d  = side_d.age_sat ? 32'd0 : diff;
    size_num_d = small_first_i ? (node_count_i - requested_nodes_i) : requested_nodes_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q     <= side_d;
      age_num_q  <= age_num_d;
      size_num_q <= size_num_d;
    end
  end

  assign valid_o    = valid_q;
  assign side_o     = side_q;
  assign age_num_o  = age_num_q;
  assign size_num_o = size_num_q;

endmodule

FILE: sv/mjp_div.sv
// ---------------------------------------------------------------------------
// mjp_div
// Pipelined restoring divider, one quotient bit per stage, for a numerator
// below the divisor: quotient = floor(num * 2^FRAC_BITS / den).
// ---------------------------------------------------------------------------
module mjp_div #(
  parameter int unsigned NW = 32
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [NW-1:0]                num_i,
  input  logic [NW-1:0]                den_i,
  output logic [mjp_pkg::FRAC_BITS-1:0] quo_o
);
  import mjp_pkg::*;

  logic [NW-1:0]        rem_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_q [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
    logic [NW-1:0]        rin;
    logic [FRAC_BITS-1:0] qin;
    logic [NW:0]          sh, sub;
    logic                 ge;
    if (k == 0) begin : g_first
      assign rin = num_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign qin = quo_q[k-1];
    end
    assign sh  = {rin, 1'b0};
    assign ge  = (sh >= {1'b0, den_i});
    assign sub = sh - {1'b0, den_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? sub[NW-1:0] : sh[NW-1:0];
        quo_q[k] <= {qin[FRAC_BITS-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[FRAC_BITS-1];

endmodule

FILE: sv/mjp_back.sv
// ---------------------------------------------------------------------------
// mjp_back
// Weight the factors, sum them, apply nice, floor and select the result.
// ---------------------------------------------------------------------------
module mjp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  mjp_pkg::side_t                side_i,
  input  logic [mjp_pkg::FRAC_BITS-1:0] age_quo_i,
  input  logic [mjp_pkg::FRAC_BITS-1:0] size_quo_i,
  input  logic                          small_first_i,
  input  logic [23:0]                   age_weight_i,
  input  logic [23:0]                   fs_weight_i,
  input  logic [23:0]                   size_weight_i,
  input  logic [23:0]                   part_weight_i,
  input  logic [23:0]                   qos_weight_i,
  output logic                          valid_o,
  output logic [31:0]                   job_priority_o,
  output logic [1:0]                    result_kind_o,
  output logic [16:0]                   fairshare_factor_o
);
  import mjp_pkg::*;

  localparam logic [SUM_W-1:0] BIAS = SUM_W'(NICE_BIAS) << FRAC_BITS;
  localparam logic [SUM_W-1:0] TWO  = SUM_W'(2) << FRAC_BITS;

  logic                valid_m_q, valid_a_q, valid_o_q;
  side_t               side_m_q, side_a_q;
  logic [FACTOR_W-1:0] age_f, size_f;
  logic [PROD_W-1:0]   p_age_q, p_fs_q, p_size_q, p_part_q, p_qos_q;
  logic [SUM_W-1:0]    sum_d, sum_q, sub, diff;
  logic [31:0]         prio;
  logic [31:0]         job_priority_q;
  logic [1:0]          kind_q;
  logic [16:0]         fs_q;

  always_comb begin
    age_f = side_i.age_sat ? FX_ONE : {1'b0, age_quo_i};
    if (side_i.size_sat) begin
      size_f = small_first_i ? '0 : FX_ONE;
    end else if (side_i.size_one) begin
      size_f = FX_ONE;
    end else begin
      size_f = {1'b0, size_quo_i};
    end
  end

  assign sum_d = SUM_W'(p_age_q) + SUM_W'(p_fs_q) + SUM_W'(p_size_q)
               + SUM_W'(p_part_q) + SUM_W'(p_qos_q) + BIAS;

  assign sub  = SUM_W'(side_a_q.nice) << FRAC_BITS;
  assign diff = sum_q - sub;

  always_comb begin
    if (sum_q < sub + TWO) begin
      prio = 32'd2;
    end else if ((diff >> FRAC_BITS) > SUM_W'(32'hFFFF_FFFF)) begin
      prio = 32'hFFFF_FFFF;
    end else begin
      prio = 32'(diff >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
      valid_a_q <= 1'b0;
      valid_o_q <= 1'b0;
    end else if (en_i) begin
      valid_m_q <= valid_i;
      valid_a_q <= valid_m_q;
      valid_o_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_m_q <= side_i;
      p_age_q  <= PROD_W'(age_f) * PROD_W'(age_weight_i);
      p_fs_q   <= PROD_W'(side_i.fs) * PROD_W'(fs_weight_i);
      p_size_q <= PROD_W'(size_f) * PROD_W'(size_weight_i);
      p_part_q <= PROD_W'(side_i.part) * PROD_W'(part_weight_i);
      p_qos_q  <= PROD_W'(side_i.qos) * PROD_W'(qos_weight_i);
      side_a_q <= side_m_q;
      sum_q    <= sum_d;
      kind_q   <= side_a_q.kind;
      case (side_a_q.kind)
        KIND_DIRECT: begin
          job_priority_q <= side_a_q.direct_priority;
          fs_q           <= '0;
        end
        KIND_NO_DET: begin
          job_priority_q <= 32'd0;
          fs_q           <= '0;
        end
        KIND_NOT_ELIG: begin
          job_priority_q <= 32'd1;
          fs_q           <= '0;
        end
        default: begin
          job_priority_q <= prio;
          fs_q           <= side_a_q.fs;
        end
      endcase
    end
  end

  assign valid_o            = valid_o_q;
  assign job_priority_o     = job_priority_q;
  assign result_kind_o      = kind_q;
  assign fairshare_factor_o = fs_q;

endmodule

FILE: sv/multifactor_job_priority.sv
// Scores one job per clock unless m_axis stalls: an item entering on s_axis
// passes one decode stage, 16 divider stages, weighting, summing and the
// output register before it leaves on m_axis. The depth is set by the two
// divisions, age over the maximum age and nodes over the cluster node
// count, each worked one quotient bit per stage. The whole pipeline holds
// while a finished item waits on m_axis; configuration is taken every cycle
// and must be written while no item is in flight.
// ---------------------------------------------------------------------------
// multifactor_job_priority
// Multifactor job priority scorer, stream in, stream out.
// ---------------------------------------------------------------------------
`include "multifactor_job_priority_assert.svh"

module multifactor_job_priority (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_time, eligible_time, direct_priority, requested_nodes,
  // normalized_shares, effective_usage, partition_norm_priority,
  // qos_norm_priority, nice_value, zero pad
  input  logic [199:0] s_axis_tdata,
  // has_details, direct_set, has_account
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // job_priority, fairshare_factor, zero pad
  output logic [55:0]  m_axis_tdata,
  // result_kind
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import mjp_pkg::*;

  logic [31:0] max_age_q;
  logic [23:0] age_w_q, fs_w_q, size_w_q, part_w_q, qos_w_q;
  logic        favor_q;
  logic [15:0] node_cnt_q;

  logic        en;
  logic        f_valid;
  side_t       f_side;
  logic [31:0] age_num;
  logic [15:0] size_num;
  logic [FRAC_BITS-1:0] age_quo, size_quo;
  logic        d_valid_q [FRAC_BITS];
  side_t       d_side_q  [FRAC_BITS];
  logic [31:0] job_priority;
  logic [1:0]  result_kind;
  logic [16:0] fs_out;

  assign cfg_ready_o   = 1'b1;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q  <= 32'd604800;
      age_w_q    <= '0;
      fs_w_q     <= '0;
      size_w_q   <= '0;
      part_w_q   <= '0;
      qos_w_q    <= '0;
      favor_q    <= 1'b0;
      node_cnt_q <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_MAX_AGE:  max_age_q  <= cfg_data_i;
        REG_AGE_W:    age_w_q    <= cfg_data_i[23:0];
        REG_FS_W:     fs_w_q     <= cfg_data_i[23:0];
        REG_SIZE_W:   size_w_q   <= cfg_data_i[23:0];
        REG_PART_W:   part_w_q   <= cfg_data_i[23:0];
        REG_QOS_W:    qos_w_q    <= cfg_data_i[23:0];
        REG_FAVOR:    favor_q    <= cfg_data_i[0];
        REG_NODE_CNT: node_cnt_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  mjp_front u_front (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .en_i                      (en),
    .valid_i                   (s_axis_tvalid),
    .now_time_i                (s_axis_tdata[31:0]),
    .eligible_time_i           (s_axis_tdata[63:32]),
    .has_details_i             (s_axis_tuser[0]),
    .direct_set_i              (s_axis_tuser[1]),
    .direct_priority_i         (s_axis_tdata[95:64]),
    .requested_nodes_i         (s_axis_tdata[111:96]),
    .has_account_i             (s_axis_tuser[2]),
    .normalized_shares_i       (s_axis_tdata[128:112]),
    .effective_usage_i         (s_axis_tdata[145:129]),
    .partition_norm_priority_i (s_axis_tdata[162:146]),
    .qos_norm_priority_i       (s_axis_tdata[179:163]),
    .nice_value_i              (s_axis_tdata[195:180]),
    .max_age_i                 (max_age_q),
    .fs_enable_i               (fs_w_q != '0),
    .small_first_i             (favor_q),
    .node_count_i              (node_cnt_q),
    .valid_o                   (f_valid),
    .side_o                    (f_side),
    .age_num_o                 (age_num),
    .size_num_o                (size_num)
  );

  mjp_div #(.NW(32)) u_age_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (age_num),
    .den_i (max_age_q),
    .quo_o (age_quo)
  );

  mjp_div #(.NW(16)) u_size_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (size_num),
    .den_i (node_cnt_q),
    .quo_o (size_quo)
  );

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_valid_q[k] <= 1'b0;
      end else if (en) begin
        d_valid_q[k] <= (k == 0) ? f_valid : d_valid_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        d_side_q[k] <= (k == 0) ? f_side : d_side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  mjp_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (en),
    .valid_i            (d_valid_q[FRAC_BITS-1]),
    .side_i             (d_side_q[FRAC_BITS-1]),
    .age_quo_i          (age_quo),
    .size_quo_i         (size_quo),
    .small_first_i      (favor_q),
    .age_weight_i       (age_w_q),
    .fs_weight_i        (fs_w_q),
    .size_weight_i      (size_w_q),
    .part_weight_i      (part_w_q),
    .qos_weight_i       (qos_w_q),
    .valid_o            (m_axis_tvalid),
    .job_priority_o     (job_priority),
    .result_kind_o      (result_kind),
    .fairshare_factor_o (fs_out)
  );

  assign m_axis_tdata = {7'd0, fs_out, job_priority};
  assign m_axis_tuser = result_kind;

  `MJP_ASSERT_OUT(a_floor, m_axis_tuser != KIND_COMPUTED || m_axis_tdata[31:0] >= 32'd2, "computed priority below floor")
  `MJP_ASSERT_OUT(a_fs_zero, m_axis_tuser == KIND_COMPUTED || m_axis_tdata[48:32] == 17'd0, "fairshare on uncomputed item")
  `MJP_ASSERT_OUT(a_fs_max, m_axis_tdata[48:32] <= FX_ONE, "fairshare factor above one")

endmodule

FILE: tb/multifactor_job_priority_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multifactor_job_priority_test
// Drives job descriptors through the priority scorer under several register
// settings and random stalls on both streams, predicts each priority and
// compares every result item field by field against the predicted one.
// ---------------------------------------------------------------------------
module multifactor_job_priority_test;
  import mjp_pkg::*;

  typedef struct {
    logic [31:0] now_t;
    logic [31:0] elig_t;
    logic        details;
    logic        direct;
    logic [31:0] direct_prio;
    logic [15:0] nodes;
    logic        account;
    logic [16:0] shares;
    logic [16:0] usage;
    logic [16:0] part;
    logic [16:0] qos;
    logic [15:0] nice;
  } job_t;

  typedef struct {
    logic [31:0] prio;
    kind_e       kind;
    logic [16:0] fs;
  } score_t;

  class priority_scoreboard;
    logic [31:0] max_age = 604800;
    logic [23:0] w_age, w_fs, w_size, w_part, w_qos;
    logic        small_first;
    logic [15:0] node_cnt = 1;
    score_t      pending_scores[$];
    int          errors;

    function void set_reg(reg_e idx, logic [31:0] v);
      case (idx)
        REG_MAX_AGE:  max_age = v;
        REG_AGE_W:    w_age = v[23:0];
        REG_FS_W:     w_fs = v[23:0];
        REG_SIZE_W:   w_size = v[23:0];
        REG_PART_W:   w_part = v[23:0];
        REG_QOS_W:    w_qos = v[23:0];
        REG_FAVOR:    small_first = v[0];
        REG_NODE_CNT: node_cnt = v[15:0];
        default: ;
      endcase
    endfunction

    function void note_job(job_t j);
      score_t s;
      logic [63:0] diff, agef, fsf, szf, pf, qf, top, total, sub;
      s.fs = '0;
      if (j.direct) begin
        s.prio = j.direct_prio;
        s.kind = KIND_DIRECT;
      end else if (!j.details) begin
        s.prio = 0;
        s.kind = KIND_NO_DET;
      end else if (j.elig_t == 0 || j.elig_t > j.now_t) begin
        s.prio = 1;
        s.kind = KIND_NOT_ELIG;
      end else begin
        s.kind = KIND_COMPUTED;
        diff = j.now_t - j.elig_t;
        agef = (diff < max_age) ? (diff << 16) / max_age : 64'd65536;
        fsf = 0;
        if (j.account && w_fs != 0) begin
          top = 64'(j.shares) + 65536;
          if (64'(j.usage) < top) begin
            fsf = (top - j.usage) >> 1;
            if (fsf > 65536) fsf = 65536;
          end
        end
        if (j.nodes >= node_cnt) szf = small_first ? 0 : 65536;
        else if (small_first) szf = (64'(node_cnt - j.nodes) << 16) / node_cnt;
        else szf = (64'(j.nodes) << 16) / node_cnt;
        pf = (j.part > 65536) ? 65536 : j.part;
        qf = (j.qos > 65536) ? 65536 : j.qos;
        total = agef * w_age + fsf * w_fs + szf * w_size + pf * w_part + qf * w_qos
              + (64'(NICE_BIAS) << 16);
        sub = 64'(j.nice) << 16;
        if (total < sub + (64'd2 << 16)) s.prio = 2;
        else begin
          total = (total - sub) >> 16;
          s.prio = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        end
        s.fs = fsf[16:0];
      end
      pending_scores.push_back(s);
    endfunction

    function void check_score(logic [31:0] prio, logic [1:0] kind, logic [16:0] fs);
      score_t e;
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected result prio=%0d kind=%0d fs=%0d", $time, prio, kind, fs);
        errors++;
        return;
      end
      e = pending_scores.pop_front();
      if (prio !== e.prio) begin
        $display("%0t: job_priority expected %0d actual %0d", $time, e.prio, prio);
        errors++;
      end
      if (kind !== e.kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (fs !== e.fs) begin
        $display("%0t: fairshare_factor expected %0d actual %0d", $time, e.fs, fs);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [55:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  priority_scoreboard sb = new();
  int send_idle_pct, recv_idle_pct;
  longint cycles;

  multifactor_job_priority DUT (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_score(m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[48:32]);

  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic write_reg(reg_e idx, logic [31:0] v);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
  endtask

  task automatic send_job(job_t j);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {8'd0, j.nice, j.qos, j.part, j.usage, j.shares, j.nodes,
                     j.direct_prio, j.elig_t, j.now_t};
    s_axis_tuser <= {j.account, j.direct, j.details};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_job(j);
    @(negedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 0;
    while (sb.pending_scores.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (30) @(negedge clk_i);
  endtask

  function automatic logic [31:0] edge_word(int bits);
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = 0;
      1: v = 1;
      2: v = (32'd1 << bits) - 1;
      default: v = $urandom;
    endcase
    if (bits < 32) v &= (32'd1 << bits) - 1;
    return v;
  endfunction

  function automatic logic [16:0] frac_val();
    case ($urandom_range(5))
      0: return 0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return $urandom_range(131071);
    endcase
  endfunction

  function automatic job_t random_job();
    job_t j;
    j.now_t = $urandom;
    j.elig_t = ($urandom_range(9) == 0) ? edge_word(32) : j.now_t - $urandom_range(2000000);
    if ($urandom_range(3) == 0) j.now_t = edge_word(32);
    j.details = ($urandom_range(9) != 0);
    j.direct = ($urandom_range(9) == 0);
    j.direct_prio = $urandom;
    j.nodes = ($urandom_range(3) == 0) ? edge_word(16) : $urandom_range(300);
    j.account = $urandom_range(1);
    j.shares = frac_val();
    j.usage = frac_val();
    j.part = frac_val();
    j.qos = frac_val();
    j.nice = ($urandom_range(3) == 0) ? edge_word(16) : 10000 + $urandom_range(200) - 100;
    return j;
  endfunction

  task automatic directed_jobs();
    job_t j;
    j = random_job();
    j.details = 1; j.direct = 0; j.now_t = 1000; j.elig_t = 1; j.nice = 10000;
    send_job(j);
    j.direct = 1; j.direct_prio = 32'hFFFF_FFFF; send_job(j);
    j.direct_prio = 0; send_job(j);
    j.direct = 0; j.details = 0; send_job(j);
    j.details = 1; j.elig_t = 0; send_job(j);
    j.elig_t = 1001; send_job(j);
    j.elig_t = 1000; send_job(j);
    j.now_t = 32'hFFFF_FFFF; j.elig_t = 1; send_job(j);
    j.nice = 16'hFFFF; send_job(j);
    j.nice = 0; send_job(j);
    j.account = 1; j.shares = 17'h1FFFF; j.usage = 0; send_job(j);
    j.shares = 0; j.usage = 17'h1FFFF; send_job(j);
    j.shares = 65536; j.usage = 65536; send_job(j);
    j.part = 17'h1FFFF; j.qos = 65536; send_job(j);
    j.nodes = 0; send_job(j);
    j.nodes = 16'hFFFF; send_job(j);
    j.account = 0; j.part = 0; j.qos = 0; send_job(j);
  endtask

  task automatic apply_setting(int n);
    logic [31:0] v[8];
    case (n)
      0: v = '{32'd0, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 1, 32'd0};
      1: v = '{32'hFFFF_FFFF, 1, 0, 1, 1, 1, 0, 32'hFFFF};
      2: v = '{32'd604800, 1000, 2000, 500, 1000, 3000, 1, 32'd100};
      3: v = '{32'd1, 0, 1, 0, 0, 0, 0, 32'd1};
      default: v = '{$urandom_range(2000000), $urandom_range(24'hFFFFFF),
                     $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                     $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                     $urandom_range(1), $urandom_range(300)};
    endcase
    for (int i = 0; i < 8; i++) write_reg(reg_e'(i), v[i]);
    cfg_valid_i <= 0;
  endtask

  initial begin
    send_idle_pct = 11;
    recv_idle_pct = 83;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    apply_setting(2);
    directed_jobs();
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 11;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      apply_setting(phase % 5 == 4 ? 4 : phase % 4);
      if (phase % 3 == 0) directed_jobs();
      for (int k = 0; k < 80; k++) send_job(random_job());
    end
    drain();
    if (sb.errors == 0 && sb.pending_scores.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+sv
sv/mjp_pkg.sv
sv/mjp_front.sv
sv/mjp_div.sv
sv/mjp_back.sv
sv/multifactor_job_priority.sv
tb/multifactor_job_priority_test.sv
